// ===== sv/mbwr_pkg.sv =====
package mbwr_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned WordW     = 16;
    localparam int unsigned PosW      = 9;
    localparam int unsigned CfgIdxW   = 1;
    localparam int unsigned HeaderLen = 7;

    localparam logic [WordW-1:0] CrcInit     = 16'hFFFF;
    localparam logic [WordW-1:0] CrcPoly     = 16'hA001;
    localparam logic [WordW-1:0] CountMinRst = 16'd1;
    localparam logic [WordW-1:0] CountMaxRst = 16'd123;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_COUNT_MIN = 1'b0,
        CFG_COUNT_MAX = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CRC       = 3'd1,
        ERR_BYTECOUNT = 3'd2,
        ERR_COUNT_LOW = 3'd3,
        ERR_COUNT_HI  = 3'd4
    } err_code_t;

    typedef struct packed {
        logic              frame_ok;
        err_code_t         error_code;
        logic [ByteW-1:0]  slave_addr;
        logic [ByteW-1:0]  function_code;
        logic [WordW-1:0]  start_offset;
        logic [WordW-1:0]  reg_count;
        logic [ByteW-1:0]  byte_count;
    } result_t;

    function automatic logic [WordW-1:0] crc_byte(
        input logic [WordW-1:0] crc_in,
        input logic [ByteW-1:0] data
    );
        logic [WordW-1:0] crc;
        crc = crc_in ^ {{(WordW-ByteW){1'b0}}, data};
        for (int i = 0; i < ByteW; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CrcPoly;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/mbwr_if.sv =====
interface mbwr_req_if;
    logic                       valid;
    logic                       ready;
    logic [mbwr_pkg::ByteW-1:0] rx_byte;
    logic                       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mbwr_res_if;
    logic                       valid;
    logic                       ready;
    logic                       frame_ok;
    logic [2:0]                 error_code;
    logic [mbwr_pkg::ByteW-1:0] slave_addr;
    logic [mbwr_pkg::ByteW-1:0] function_code;
    logic [mbwr_pkg::WordW-1:0] start_offset;
    logic [mbwr_pkg::WordW-1:0] reg_count;
    logic [mbwr_pkg::ByteW-1:0] byte_count;

    modport source (output valid, output frame_ok, output error_code, output slave_addr,
                    output function_code, output start_offset, output reg_count,
                    output byte_count, input ready);
    modport sink   (input valid, input frame_ok, input error_code, input slave_addr,
                    input function_code, input start_offset, input reg_count,
                    input byte_count, output ready);
endinterface

// ===== sv/modbus_write_multiple_request_checker.sv =====
// channel  | dir | handshake    | payload
// req      | in  | valid/ready  | rx_byte, frame_start
// res      | out | valid/ready  | frame_ok, error_code, slave_addr, function_code,
//          |     |              | start_offset, reg_count, byte_count
// cfg      | in  | cfg_we       | cfg_index, cfg_wdata
//
// One byte per cycle; the CRC update, header capture and verdict sit in one stage.
// A verdict appears on res in the cycle after the last CRC byte is taken.
// rst_n resets frame state, CRC (to 16'hFFFF) and limits (count_min 1, count_max 123).
// req is held off only while a verdict waits in the output register and res is stalled.
module modbus_write_multiple_request_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    mbwr_req_if.sink                     req,
    mbwr_res_if.source                   res,
    input  logic                         cfg_we,
    input  logic [mbwr_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [mbwr_pkg::WordW-1:0]   cfg_wdata
);

    logic [mbwr_pkg::WordW-1:0] count_min_reg;
    logic [mbwr_pkg::WordW-1:0] count_max_reg;
    logic                       out_valid_reg, out_valid_next;
    mbwr_pkg::result_t          out_reg;
    mbwr_pkg::result_t          verdict;
    logic                       verdict_valid;
    logic                       accept;

    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    mbwr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (req.rx_byte),
        .frame_start (req.frame_start),
        .count_min   (count_min_reg),
        .count_max   (count_max_reg),
        .res_valid   (verdict_valid),
        .res         (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_min_reg <= mbwr_pkg::CountMinRst;
            count_max_reg <= mbwr_pkg::CountMaxRst;
        end
        else if (cfg_we)
        begin
            unique case (mbwr_pkg::cfg_index_t'(cfg_index))
                mbwr_pkg::CFG_COUNT_MIN: count_min_reg <= cfg_wdata;
                mbwr_pkg::CFG_COUNT_MAX: count_max_reg <= cfg_wdata;
                default:                 count_max_reg <= count_max_reg;
            endcase
        end
    end

    always_comb
    begin
        if (verdict_valid)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // hold the verdict until taken
    always_ff @(posedge clk)
    begin
        if (verdict_valid)
            out_reg <= verdict;
    end

    assign res.valid         = out_valid_reg;
    assign res.frame_ok      = out_reg.frame_ok;
    assign res.error_code    = out_reg.error_code;
    assign res.slave_addr    = out_reg.slave_addr;
    assign res.function_code = out_reg.function_code;
    assign res.start_offset  = out_reg.start_offset;
    assign res.reg_count     = out_reg.reg_count;
    assign res.byte_count    = out_reg.byte_count;

endmodule

// ===== sv/mbwr_parser.sv =====
module mbwr_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [mbwr_pkg::ByteW-1:0] rx_byte,
    input  logic                       frame_start,
    input  logic [mbwr_pkg::WordW-1:0] count_min,
    input  logic [mbwr_pkg::WordW-1:0] count_max,
    output logic                       res_valid,
    output mbwr_pkg::result_t          res
);

    logic                       in_frame_reg, in_frame_next;
    logic [mbwr_pkg::PosW-1:0]  pos_reg, pos_next;
    logic [mbwr_pkg::WordW-1:0] crc_reg, crc_next;
    logic [mbwr_pkg::ByteW-1:0] slave_reg, slave_next;
    logic [mbwr_pkg::ByteW-1:0] fcode_reg, fcode_next;
    logic [mbwr_pkg::WordW-1:0] offset_reg, offset_next;
    logic [mbwr_pkg::WordW-1:0] count_reg, count_next;
    logic [mbwr_pkg::ByteW-1:0] bcount_reg, bcount_next;
    logic [mbwr_pkg::ByteW-1:0] crc_lo_reg, crc_lo_next;

    logic                       open;
    logic [mbwr_pkg::PosW-1:0]  pos;
    logic [mbwr_pkg::WordW-1:0] crc;
    logic [mbwr_pkg::WordW-1:0] crc_upd;
    logic [mbwr_pkg::PosW-1:0]  data_end;
    logic [mbwr_pkg::WordW-1:0] rx_crc;
    logic [mbwr_pkg::WordW-1:0] half_bcount;
    mbwr_pkg::err_code_t        code;

    assign open     = frame_start || in_frame_reg;
    assign pos      = frame_start ? '0 : pos_reg;
    assign crc      = frame_start ? mbwr_pkg::CrcInit : crc_reg;
    assign crc_upd  = mbwr_pkg::crc_byte(crc, rx_byte);
    assign data_end = mbwr_pkg::PosW'(mbwr_pkg::HeaderLen)
                      + {{(mbwr_pkg::PosW-mbwr_pkg::ByteW){1'b0}}, bcount_reg};
    assign rx_crc   = {rx_byte, crc_lo_reg};
    assign half_bcount = {{(mbwr_pkg::WordW-mbwr_pkg::ByteW+1){1'b0}},
                          bcount_reg[mbwr_pkg::ByteW-1:1]};

    always_comb
    begin
        priority if (rx_crc != crc_reg)
            code = mbwr_pkg::ERR_CRC;
        else if (count_reg != half_bcount)
            code = mbwr_pkg::ERR_BYTECOUNT;
        else if (count_reg < count_min)
            code = mbwr_pkg::ERR_COUNT_LOW;
        else if (count_reg > count_max)
            code = mbwr_pkg::ERR_COUNT_HI;
        else
            code = mbwr_pkg::ERR_NONE;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        slave_next    = slave_reg;
        fcode_next    = fcode_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        bcount_next   = bcount_reg;
        crc_lo_next   = crc_lo_reg;
        res_valid     = 1'b0;

        if (accept && open)
        begin
            in_frame_next = 1'b1;
            pos_next      = pos + mbwr_pkg::PosW'(1);
            priority if (pos < mbwr_pkg::PosW'(mbwr_pkg::HeaderLen))
            begin
                crc_next = crc_upd;
                unique case (pos[2:0])
                    3'd0:    slave_next = rx_byte;
                    3'd1:    fcode_next = rx_byte;
                    3'd2:    offset_next[15:8] = rx_byte;
                    3'd3:    offset_next[7:0]  = rx_byte;
                    3'd4:    count_next[15:8]  = rx_byte;
                    3'd5:    count_next[7:0]   = rx_byte;
                    default: bcount_next = rx_byte;
                endcase
            end
            else if (pos < data_end)
            begin
                crc_next = crc_upd;
            end
            else if (pos == data_end)
            begin
                crc_lo_next = rx_byte;
            end
            else
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                res_valid     = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.frame_ok      = (code == mbwr_pkg::ERR_NONE);
        res.error_code    = code;
        res.slave_addr    = slave_reg;
        res.function_code = fcode_reg;
        res.start_offset  = offset_reg;
        res.reg_count     = count_reg;
        res.byte_count    = bcount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= mbwr_pkg::CrcInit;
            slave_reg    <= '0;
            fcode_reg    <= '0;
            offset_reg   <= '0;
            count_reg    <= '0;
            bcount_reg   <= '0;
            crc_lo_reg   <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            slave_reg    <= slave_next;
            fcode_reg    <= fcode_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            bcount_reg   <= bcount_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

endmodule

// ===== sv/mbwr_checker.sv =====
module mbwr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       res_frame_ok,
    input logic [2:0]                 res_error_code,
    input logic [mbwr_pkg::WordW-1:0] res_reg_count,
    input logic [mbwr_pkg::ByteW-1:0] res_byte_count
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_error_code)
            && $stable(res_reg_count) && $stable(res_byte_count))
        else $error("stalled item changed");

    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_frame_ok == (res_error_code == mbwr_pkg::ERR_NONE)))
        else $error("frame_ok disagrees with error_code");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_frame_ok |->
            res_reg_count == {{(mbwr_pkg::WordW-mbwr_pkg::ByteW+1){1'b0}},
                              res_byte_count[mbwr_pkg::ByteW-1:1]})
        else $error("accepted frame with count not matching byte count");

    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(res_valid) && res_valid |-> $past(req_valid && req_ready))
        else $error("verdict without a taken item");

endmodule

bind modbus_write_multiple_request_checker mbwr_checker u_mbwr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_frame_ok   (res.frame_ok),
    .res_error_code (res.error_code),
    .res_reg_count  (res.reg_count),
    .res_byte_count (res.byte_count)
);
